>>> design/dsre_pkg.sv
// ----------------------------------------------------------------------------
// Decayed success-rate estimator package
// Shared widths, codes, reset values and the decay table generator.
// ----------------------------------------------------------------------------
package dsre_pkg;

    // Fixed field and state widths
    localparam int ACC_W      = 48;
    localparam int EST_W      = 17;
    localparam int Q_W        = 16;
    localparam int OUTCOME_W  = 17;
    localparam int EPS_W      = 16;
    localparam int LAMBDA_W   = 24;
    localparam int MODE_W     = 2;
    localparam int TIME_IN_W  = 32;
    localparam int ADD_W      = 18;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider step counter width
    localparam int DIV_CNT_W = 4;

    // Parameter defaults
    localparam int ACC_FRAC_BITS_DEF     = 24;
    localparam int TIME_BITS_DEF         = 32;
    localparam int DECAY_TABLE_DEPTH_DEF = 256;

    // Constants
    localparam logic [EPS_W-1:0]     EPSILON_RESET = 16'd655;
    localparam logic [LAMBDA_W-1:0]  LAMBDA_RESET  = 24'd6554;
    localparam logic [EST_W-1:0]     ONE_Q16       = 17'd65536;
    localparam logic [EST_W-1:0]     LOG2E_Q16     = 17'd94548;
    localparam logic [63:0]          LN2_Q32       = 64'd2977044472;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIOR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd2;

    // Register indexes (paddr bit 2)
    localparam logic REG_EPSILON = 1'b0;
    localparam logic REG_LAMBDA  = 1'b1;

    // exp(-z) for z in Q0.32, result rounded to Q0.16 and capped at 65535.
    // Truncated Taylor terms up to the twelfth power; evaluated at elaboration only.
    function automatic logic [15:0] exp_neg_q16(input logic [63:0] z);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] prod;
        logic [63:0] r;
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 12; n++) begin
            prod = term * z;
            term = (prod >> 32) / 64'(n);
            if ((n & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = (pos > neg) ? (pos - neg) : 64'd0;
        r = (r + 64'd32768) >> 16;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction

    // Clamp a Q1.16 value to 1.0
    function automatic logic [EST_W-1:0] clamp_q16(input logic [EST_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

>>> design/decayed_success_rate_estimator_unit.sv
// ----------------------------------------------------------------------------
// Decayed success-rate estimator
// Time-decayed success sum and weight with a sum/weight estimate per item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Carries
//  s_*       in         s_valid/s_ready  mode, event_time, outcome, prior_rate
//  m_*       out        m_valid/m_ready  success_estimate, saturated
//  APB       in/out     psel/penable     epsilon_q16 (0x0), lambda_q16 (0x4)
//
//  Updates pass through the decay factor states (MX, MY, TBL, F), then ML, MH
//  and ACC once per accumulator on the shared 32x24 multiplier, then the
//  divider (setup and 16 quotient bits), the result load and idle.
//  Restarts skip the multiplier; a clamped estimate skips the divider.
//  Synchronous reset, no clearing pass. A waiting result does not block the
//  next item; only the final state stalls while the previous one is unread.
//
module decayed_success_rate_estimator_unit #(
    parameter int ACC_FRAC_BITS     = dsre_pkg::ACC_FRAC_BITS_DEF,
    parameter int TIME_BITS         = dsre_pkg::TIME_BITS_DEF,
    parameter int DECAY_TABLE_DEPTH = dsre_pkg::DECAY_TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dsre_pkg::MODE_W-1:0]         s_mode,
    input  logic [dsre_pkg::TIME_IN_W-1:0]      s_event_time,
    input  logic [dsre_pkg::OUTCOME_W-1:0]      s_outcome,
    input  logic [dsre_pkg::OUTCOME_W-1:0]      s_prior_rate,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dsre_pkg::EST_W-1:0]          m_success_estimate,
    output logic                                m_saturated,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsre_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dsre_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dsre_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dsre_pkg::*;

    localparam int ACC_SHIFT = ACC_FRAC_BITS - Q_W;
    localparam int IDX_W     = $clog2(DECAY_TABLE_DEPTH);
    localparam int DTW_W     = TIME_BITS + 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MX,
        S_MY,
        S_TBL,
        S_F,
        S_ML,
        S_MH,
        S_ACC,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [EPS_W-1:0]        epsilon_reg;
    logic [LAMBDA_W-1:0]     lambda_reg;
    logic [ACC_W-1:0]        sum_reg;
    logic [ACC_W-1:0]        weight_reg;
    logic [TIME_BITS-1:0]    last_time_reg;
    logic [TIME_BITS-1:0]    dt_reg;
    logic [EST_W-1:0]        outcome_reg;
    logic                    big_dt_reg;
    logic                    f_zero_reg;
    logic                    f_one_reg;
    logic [4:0]              ip_reg;
    logic [15:0]             tbl_reg;
    logic [EST_W-1:0]        f_reg;
    logic [MUL_P_W-1:0]      prod_reg;
    logic [40:0]             plo_reg;
    logic                    acc_sel_reg;
    logic                    sat_reg;
    logic [ACC_W-1:0]        rem_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [EST_W-1:0]        est_reg;
    logic                    m_valid_reg;
    logic [EST_W-1:0]        m_success_estimate_reg;
    logic                    m_saturated_reg;

    // Decay table: entry i = 2^-(i/DEPTH) in Q0.16
    logic [15:0] decay_rom [DECAY_TABLE_DEPTH];

    for (genvar g = 0; g < DECAY_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [63:0] Z = (64'(g) * LN2_Q32) / 64'(DECAY_TABLE_DEPTH);
        assign decay_rom[g] = exp_neg_q16(Z);
    end

    // Input side: time delta and clamped fields
    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] dt_in;
    logic [EST_W-1:0]     outcome_in;
    logic [EST_W-1:0]     prior_in;
    logic                 s_fire;

    assign t_in       = TIME_BITS'(s_event_time);
    assign dt_in      = (t_in > last_time_reg) ? (t_in - last_time_reg) : '0;
    assign outcome_in = clamp_q16(s_outcome);
    assign prior_in   = clamp_q16(s_prior_rate);
    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;

    // Delta split: low 32 bits feed the multiplier, the rest forces f = 0
    logic [DTW_W-1:0] dt_wide;
    logic             big_dt;

    assign dt_wide = {32'b0, dt_reg};
    assign big_dt  = |dt_wide[DTW_W-1:32];

    // Shared multiplier operand select
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [ACC_W-1:0]   acc_cur;

    assign acc_cur = acc_sel_reg ? weight_reg : sum_reg;

    always_comb begin
        case (state_reg)
            S_MX: begin
                mul_a = dt_wide[31:0];
                mul_b = lambda_reg;
            end
            S_MY: begin
                mul_a = MUL_A_W'(LOG2E_Q16);
                mul_b = prod_reg[23:0];
            end
            S_ML: begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = acc_cur[23:0];
            end
            S_MH: begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = acc_cur[47:24];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // Log2 scaling: y = (x * log2(e) + half) >> 16, table index from fraction
    logic [41:0]        y_full;
    logic [25:0]        y_val;
    logic [IDX_W+15:0]  idx_prod;
    logic [IDX_W-1:0]   tbl_idx;

    assign y_full   = 42'(prod_reg[40:0]) + 42'd32768;
    assign y_val    = y_full[41:16];
    assign idx_prod = (IDX_W+16)'(y_val[15:0]) * (IDX_W+16)'(DECAY_TABLE_DEPTH);
    assign tbl_idx  = idx_prod[IDX_W+15:16];

    // Accumulator update: ((f * acc) >> 16) + addend, saturating
    logic [ADD_W-1:0] addend;
    logic [49:0]      acc_sum;
    logic [ACC_W-1:0] acc_next;
    logic             acc_sat;

    assign addend   = acc_sel_reg ? (ADD_W'(ONE_Q16) + ADD_W'(epsilon_reg))
                                  : ADD_W'(outcome_reg);
    assign acc_sum  = (50'(prod_reg[40:0]) << 8) + 50'(plo_reg >> 16)
                    + (50'(addend) << ACC_SHIFT);
    assign acc_sat  = |acc_sum[49:48];
    assign acc_next = acc_sat ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    // Restoring divider step
    logic [ACC_W:0]   rem_sh;
    logic             rem_ge;
    logic [ACC_W-1:0] rem_next;
    logic [Q_W-1:0]   quo_next;

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, weight_reg});
    assign rem_next = rem_ge ? ACC_W'(rem_sh - {1'b0, weight_reg}) : rem_sh[ACC_W-1:0];
    assign quo_next = {quo_reg[Q_W-2:0], rem_ge};

    // Sequencer, datapath state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sum_reg       <= ACC_W'(1) << ACC_FRAC_BITS;
            weight_reg    <= ACC_W'(2) << ACC_FRAC_BITS;
            last_time_reg <= '0;
            acc_sel_reg   <= 1'b0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        sat_reg     <= 1'b0;
                        acc_sel_reg <= 1'b0;
                        outcome_reg <= outcome_in;
                        case (s_mode)
                            MODE_UPDATE: begin
                                dt_reg        <= dt_in;
                                last_time_reg <= t_in;
                                state_reg     <= S_MX;
                            end
                            MODE_PRIOR: begin
                                sum_reg       <= ACC_W'(prior_in) << ACC_SHIFT;
                                weight_reg    <= ACC_W'(ADD_W'(ONE_Q16) + ADD_W'(epsilon_reg))
                                                 << ACC_SHIFT;
                                last_time_reg <= '0;
                                state_reg     <= S_DIV_INIT;
                            end
                            MODE_DEFAULT: begin
                                sum_reg       <= ACC_W'(1) << ACC_FRAC_BITS;
                                weight_reg    <= ACC_W'(2) << ACC_FRAC_BITS;
                                last_time_reg <= '0;
                                state_reg     <= S_DIV_INIT;
                            end
                            default: begin
                                state_reg <= S_DIV_INIT;
                            end
                        endcase
                    end
                end

                // x = lambda * dt
                S_MX: begin
                    prod_reg   <= mul_p;
                    big_dt_reg <= big_dt;
                    state_reg  <= S_MY;
                end

                // Classify x, then scale by log2(e)
                S_MY: begin
                    f_zero_reg <= big_dt_reg || (|prod_reg[MUL_P_W-1:24]);
                    f_one_reg  <= (prod_reg == '0);
                    prod_reg   <= mul_p;
                    state_reg  <= S_TBL;
                end

                // Look up 2^-fraction, keep the integer shift
                S_TBL: begin
                    tbl_reg   <= decay_rom[tbl_idx];
                    ip_reg    <= y_val[20:16];
                    if (y_val[25:16] >= 10'd17) begin
                        f_zero_reg <= 1'b1;
                    end
                    state_reg <= S_F;
                end

                // Form the decay factor
                S_F: begin
                    if (f_one_reg) begin
                        f_reg <= ONE_Q16;
                    end else if (f_zero_reg) begin
                        f_reg <= '0;
                    end else begin
                        f_reg <= EST_W'(tbl_reg >> ip_reg);
                    end
                    state_reg <= S_ML;
                end

                // Low partial product
                S_ML: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MH;
                end

                // High partial product, hold the low one
                S_MH: begin
                    plo_reg   <= prod_reg[40:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_ACC;
                end

                // Combine, add, saturate; then advance to weight or divide
                S_ACC: begin
                    if (acc_sel_reg) begin
                        weight_reg <= acc_next;
                        state_reg  <= S_DIV_INIT;
                    end else begin
                        sum_reg     <= acc_next;
                        acc_sel_reg <= 1'b1;
                        state_reg   <= S_ML;
                    end
                    if (acc_sat) begin
                        sat_reg <= 1'b1;
                    end
                end

                // Clamp at 1.0 or start the divider
                S_DIV_INIT: begin
                    if (sum_reg >= weight_reg) begin
                        est_reg   <= ONE_Q16;
                        state_reg <= S_DONE;
                    end else begin
                        rem_reg   <= sum_reg;
                        quo_reg   <= '0;
                        cnt_reg   <= {DIV_CNT_W{1'b1}};
                        state_reg <= S_DIV;
                    end
                end

                // One quotient bit per cycle
                S_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        est_reg   <= EST_W'(quo_next);
                        state_reg <= S_DONE;
                    end
                end

                // Load the output register once it is free
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_success_estimate_reg <= est_reg;
                        m_saturated_reg        <= sat_reg;
                        state_reg              <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_success_estimate = m_success_estimate_reg;
    assign m_saturated        = m_saturated_reg;

    // Configuration registers
    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg <= EPSILON_RESET;
            lambda_reg  <= LAMBDA_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_EPSILON: epsilon_reg <= pwdata[EPS_W-1:0];
                REG_LAMBDA:  lambda_reg  <= pwdata[LAMBDA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_EPSILON: prdata = APB_DATA_W'(epsilon_reg);
            REG_LAMBDA:  prdata = APB_DATA_W'(lambda_reg);
            default:     prdata = '0;
        endcase
    end

    // Divider remainder stays below the divisor
    a_rem_below_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < weight_reg))
        else $error("divider remainder not below weight");

    // Decay factor never exceeds 1.0
    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ML) |-> (f_reg <= ONE_Q16))
        else $error("decay factor above 1.0");

    // An accepted item starts the sequencer
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != S_IDLE))
        else $error("accepted item did not start the sequencer");

    // Restarts clear the time stamp
    a_restart_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_mode == MODE_PRIOR || s_mode == MODE_DEFAULT))
        |=> (last_time_reg == '0))
        else $error("restart did not clear last time");

    // A finished item reaches the output register and frees the sequencer
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished item not loaded into output register");

endmodule
